@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the moving average filter modules.
// Every user must have clk_i and rst_ni (active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while in reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds, off while in reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

@@ hw/rtl/maf_pkg.sv @@
// Shared widths, types and helpers of the moving average filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package maf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_WINDOW  = 64;
  localparam int LEN_W       = 7;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int SUM_W       = SAMPLE_W + IDX_W;
  localparam int CNT_W       = $clog2(SUM_W);
  localparam int REM_W       = LEN_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_WINDOW);

  typedef logic signed [SUM_W-1:0] sum_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map the raw register to a usable window length: zero acts as one,
  // anything above the store depth saturates.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_WINDOW)) begin
      res = LEN_W'(MAX_WINDOW);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/maf_front.sv @@
// Front end: accepts samples, keeps the ring store and the running sum.
// Depends on maf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module maf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [maf_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] sample_i,
  input  maf_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output maf_pkg::sum_t                 push_sum_o,
  output logic [maf_pkg::LEN_W-1:0]     len_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic                                state_q, state_d;
  logic [maf_pkg::LEN_W-1:0]           len_q;
  logic [maf_pkg::LEN_W-1:0]           len_eff;
  logic [maf_pkg::IDX_W-1:0]           idx_q, idx_d;
  maf_pkg::sum_t                       sum_q, sum_d;
  logic [maf_pkg::MAX_WINDOW-1:0]      vld_q;
  logic signed [maf_pkg::SAMPLE_W-1:0] mem_q [maf_pkg::MAX_WINDOW];
  logic signed [maf_pkg::SAMPLE_W-1:0] rd_q;
  logic signed [maf_pkg::SAMPLE_W-1:0] sample_q;
  logic [maf_pkg::IDX_W-1:0]           pos_q, pos;
  logic signed [maf_pkg::SAMPLE_W-1:0] old_val;
  logic                                accept;

  assign len_eff    = maf_pkg::eff_len(len_q);
  assign len_o      = len_eff;
  assign in_stall_o = (state_q != S_IDLE) | q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;

  // Pick the slot to overwrite; restart at zero if the index ran past the window
  assign pos = ({1'b0, idx_q} >= len_eff) ? '0 : idx_q;

  // Entry never written since the last clear reads as zero
  assign old_val = vld_q[pos_q] ? rd_q : '0;

  // Add the new beat, drop the replaced entry
  assign sum_d = sum_q
               + maf_pkg::SUM_W'(sample_q)
               - maf_pkg::SUM_W'(old_val);

  // Advance and wrap the write index
  assign idx_d = ({1'b0, pos_q} == (len_eff - maf_pkg::LEN_W'(1))) ? '0
               : pos_q + maf_pkg::IDX_W'(1);

  assign state_d    = (state_q == S_IDLE) ? (accept ? S_UPD : S_IDLE) : S_IDLE;
  assign push_o     = (state_q == S_UPD);
  assign push_sum_o = sum_d;

  // Ring store and beat hold registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= mem_q[pos];
      sample_q <= sample_i;
      pos_q    <= pos;
    end
    if (state_q == S_UPD) begin
      mem_q[pos_q] <= sample_q;
    end
  end

  // Control, sum and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= maf_pkg::LEN_RESET;
      idx_q   <= '0;
      sum_q   <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
        idx_q <= '0;
        sum_q <= '0;
        vld_q <= '0;
      end else if (state_q == S_UPD) begin
        idx_q        <= idx_d;
        sum_q        <= sum_d;
        vld_q[pos_q] <= 1'b1;
      end
    end
  end

  `ASSERT_CHK(a_idx_in_window, ({1'b0, idx_q} < len_eff), "write index outside window")

endmodule

@@ hw/rtl/maf_queue.sv @@
// Short queue of running sums between the front end and the divider.
// Depends on maf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module maf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  maf_pkg::sum_t     push_data_i,
  input  logic              pop_i,
  output maf_pkg::sum_t     pop_data_o,
  output maf_pkg::q_stat_t  stat_o
);

  maf_pkg::sum_t               mem_q [maf_pkg::QUEUE_DEPTH];
  logic [maf_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [maf_pkg::QCNT_W-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == maf_pkg::QCNT_W'(maf_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + maf_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + maf_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + maf_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - maf_pkg::QCNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_push_full, (push_i && stat_o.full), "push into full queue")
  `ASSERT_NEVER(a_pop_empty, (pop_i && stat_o.empty), "pop from empty queue")

endmodule

@@ hw/rtl/maf_div.sv @@
// Back end: divides each running sum by the window length, one quotient bit
// per cycle, and holds the mean in an output register.
// Depends on maf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module maf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  maf_pkg::q_stat_t                    q_stat_i,
  output logic                                pop_o,
  input  maf_pkg::sum_t                       pop_sum_i,
  input  logic [maf_pkg::LEN_W-1:0]           len_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [maf_pkg::SAMPLE_W-1:0] mean_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [maf_pkg::CNT_W-1:0]           cnt_q;
  logic [maf_pkg::SUM_W-1:0]           quo_q, quo_d;
  logic [maf_pkg::REM_W-1:0]           rem_q, rem_d;
  logic [maf_pkg::REM_W-1:0]           rem_sh;
  logic                                neg_q;
  logic                                ge;
  logic [maf_pkg::SUM_W-1:0]           mag;
  logic [maf_pkg::SUM_W-1:0]           qs;
  logic                                out_valid_q;
  logic signed [maf_pkg::SAMPLE_W-1:0] mean_q;
  logic                                load_out;

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;

  // Magnitude of the incoming sum
  assign mag = pop_sum_i[maf_pkg::SUM_W-1] ? (~pop_sum_i + maf_pkg::SUM_W'(1)) : pop_sum_i;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q[maf_pkg::REM_W-2:0], quo_q[maf_pkg::SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, len_i});
  assign rem_d  = ge ? (rem_sh - {1'b0, len_i}) : rem_sh;
  assign quo_d  = {quo_q[maf_pkg::SUM_W-2:0], ge};

  // Restore the sign; truncation toward zero falls out of dividing magnitudes
  assign qs = neg_q ? (~quo_q + maf_pkg::SUM_W'(1)) : quo_q;

  assign pop_o    = (state_q == B_IDLE) & ~q_stat_i.empty;
  assign load_out = (state_q == B_DONE) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o) state_d = B_RUN;
      end
      B_RUN: begin
        if (cnt_q == maf_pkg::CNT_W'(maf_pkg::SUM_W - 1)) state_d = B_DONE;
      end
      B_DONE: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath registers of the divider and the output beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= pop_sum_i[maf_pkg::SUM_W-1];
    end else if (state_q == B_RUN) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (load_out) begin
      mean_q <= qs[maf_pkg::SAMPLE_W-1:0];
    end
  end

  // Control: state, step count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == B_RUN) begin
        cnt_q <= cnt_q + maf_pkg::CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ASSERT_CHK(a_rem_below_len, (state_q == B_RUN |-> rem_q < {1'b0, len_i}), "remainder not below divisor")

endmodule

@@ hw/rtl/moving_average_filter.sv @@
// Moving average filter top level: sliding mean; wires maf_front, maf_queue and maf_div.
// The bit-serial divider takes one sum at a time from the queue, runs 22 steps
//   on it and loads the mean into the output register, waiting while the output
//   is stalled; the front end stalls input while the queue of sums is full.
// Reset: asynchronous, active low; window length returns to 64, store reads as zero
//   through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

module moving_average_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [maf_pkg::LEN_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [maf_pkg::SAMPLE_W-1:0] mean_o
);

  logic                      push;
  logic                      pop;
  maf_pkg::sum_t             push_sum;
  maf_pkg::sum_t             pop_sum;
  maf_pkg::q_stat_t          q_stat;
  logic [maf_pkg::LEN_W-1:0] len_eff;
  logic                      cfg_wr;

  // Register writes are taken at once
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  maf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_wr),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_sum_o (push_sum),
    .len_o      (len_eff)
  );

  maf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_sum),
    .pop_i      (pop),
    .pop_data_o (pop_sum),
    .stat_o     (q_stat)
  );

  maf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .pop_sum_i  (pop_sum),
    .len_i      (len_eff),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .mean_o     (mean_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the moving average filter: random samples and window
// lengths, random gaps and output stalls, each mean checked against a local predictor.
// Depends on maf_pkg and the moving_average_filter RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 20;

  localparam logic signed [maf_pkg::SAMPLE_W-1:0] S_MAX =
    {1'b0, {(maf_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [maf_pkg::SAMPLE_W-1:0] S_MIN =
    {1'b1, {(maf_pkg::SAMPLE_W-1){1'b0}}};

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [maf_pkg::LEN_W-1:0]           cfg_data_i  = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic signed [maf_pkg::SAMPLE_W-1:0] sample_i    = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [maf_pkg::SAMPLE_W-1:0] mean_o;

  // Predictor state: ring of samples, write slot, window sum, raw length register
  logic signed [maf_pkg::SAMPLE_W-1:0] window_mem [maf_pkg::MAX_WINDOW];
  int unsigned                         fill_pos;
  longint                              window_sum;
  logic [maf_pkg::LEN_W-1:0]           window_reg;

  // Means still owed by the filter, oldest first
  logic signed [maf_pkg::SAMPLE_W-1:0] mean_q [$];

  int err_count     = 0;
  int samples_sent  = 0;
  int means_seen    = 0;
  int settings_used = 0;
  int stall_left    = 0;
  bit no_idle       = 1'b0;

  moving_average_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_o      (mean_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  // Empty the window and latch a new length register value
  function automatic void clear_window(input logic [maf_pkg::LEN_W-1:0] len);
    window_reg = len;
    for (int i = 0; i < maf_pkg::MAX_WINDOW; i++) begin
      window_mem[i] = '0;
    end
    fill_pos   = 0;
    window_sum = 0;
  endfunction

  // Push one sample into the window and return the truncated mean
  function automatic logic signed [maf_pkg::SAMPLE_W-1:0] next_mean(
    input logic signed [maf_pkg::SAMPLE_W-1:0] x
  );
    int unsigned span;
    int unsigned slot;
    longint      quot;
    if (window_reg == '0) begin
      span = 1;
    end else if (window_reg > maf_pkg::MAX_WINDOW) begin
      span = maf_pkg::MAX_WINDOW;
    end else begin
      span = window_reg;
    end
    slot = (fill_pos >= span) ? 0 : fill_pos;
    window_sum += longint'(x) - longint'(window_mem[slot]);
    window_mem[slot] = x;
    fill_pos = (slot < span - 1) ? slot + 1 : 0;
    // signed division truncates toward zero
    quot = window_sum / longint'(span);
    return quot[maf_pkg::SAMPLE_W-1:0];
  endfunction

  // Send one sample beat after a random gap; valid stays high until told otherwise
  task automatic send_sample(input logic signed [maf_pkg::SAMPLE_W-1:0] x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= x;
    do @(posedge clk_i); while (in_stall_o);
    mean_q.push_back(next_mean(x));
    samples_sent++;
  endtask

  // Drop valid and wait until every owed mean has come back
  task automatic drain_means();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (mean_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (mean_q.size() != 0) begin
      report_mismatch($sformatf("%0d means never arrived", mean_q.size()));
      mean_q.delete();
    end
  endtask

  // Write the window length once the filter is idle
  task automatic write_window(input logic [maf_pkg::LEN_W-1:0] len);
    drain_means();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    clear_window(len);
    settings_used++;
  endtask

  // Check each accepted mean beat, then hold stall for a random number of valid cycles
  always @(posedge clk_i) begin : mean_check
    logic signed [maf_pkg::SAMPLE_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        means_seen++;
        if (mean_q.size() == 0) begin
          report_mismatch($sformatf("unexpected mean %0d", mean_o));
        end else begin
          want = mean_q.pop_front();
          if (mean_o !== want) begin
            report_mismatch($sformatf("mean %0d, expected %0d", mean_o, want));
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Reset length of 64: zeros in the store still count during warm-up
  task automatic test_default_window();
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd100);
  endtask

  // Length one passes samples through; length two shows truncation toward zero
  task automatic test_short_windows();
    write_window(maf_pkg::LEN_W'(1));
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    write_window(maf_pkg::LEN_W'(2));
    send_sample(16'sd1);
    send_sample(-16'sd2);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MAX);
  endtask

  // A length of zero acts as one
  task automatic test_zero_window();
    write_window('0);
    send_sample(-16'sd5);
    send_sample(16'sd7);
    send_sample(S_MIN);
  endtask

  // Lengths above the store depth saturate to it
  task automatic test_saturated_window();
    write_window({maf_pkg::LEN_W{1'b1}});
    send_sample(S_MIN);
    send_sample(-16'sd3);
    send_sample(S_MAX);
    write_window(maf_pkg::LEN_W'(maf_pkg::MAX_WINDOW + 1));
    send_sample(S_MAX);
    send_sample(S_MAX);
  endtask

  // Random bursts, each under a fresh window length and idling mode
  task automatic test_random_windows();
    logic [maf_pkg::LEN_W-1:0]           len;
    logic signed [maf_pkg::SAMPLE_W-1:0] x;
    logic signed [maf_pkg::SAMPLE_W-1:0] rail;
    int                                  start;
    int                                  burst;
    int                                  flavor;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = maf_pkg::LEN_W'(1);
        2, 3:    len = maf_pkg::LEN_W'(maf_pkg::MAX_WINDOW);
        4:       len = {maf_pkg::LEN_W{1'b1}};
        5:       len = maf_pkg::LEN_W'($urandom_range(maf_pkg::MAX_WINDOW + 1, 127));
        6, 7:    len = maf_pkg::LEN_W'($urandom_range(17, maf_pkg::MAX_WINDOW));
        default: len = maf_pkg::LEN_W'($urandom_range(2, 16));
      endcase
      write_window(len);
      no_idle = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(20, 160);
      // keep the total close to the planned item count
      if (burst > RANDOM_ITEMS - (samples_sent - start)) begin
        burst = RANDOM_ITEMS - (samples_sent - start);
      end
      flavor  = (len >= maf_pkg::MAX_WINDOW) ? $urandom_range(0, 1) : $urandom_range(0, 3);
      rail    = $urandom_range(0, 1) ? S_MAX : S_MIN;
      repeat (burst) begin
        case (flavor)
          // hold the sum near a rail, with some noise
          0: x = ($urandom_range(0, 9) != 0) ? rail : maf_pkg::SAMPLE_W'($urandom);
          1: x = $urandom_range(0, 1) ? S_MAX : S_MIN;
          2: x = maf_pkg::SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
          default: x = maf_pkg::SAMPLE_W'($urandom);
        endcase
        send_sample(x);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_window(maf_pkg::LEN_RESET);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_short_windows();
    test_zero_window();
    test_saturated_window();
    test_random_windows();
    drain_means();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d means over %0d window settings,",
             samples_sent, means_seen, settings_used);
    $display("including zero, one, full and saturated lengths; %0d mismatches.", err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #5_000_000;
    $display("Run timed out with %0d means outstanding.", mean_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
